### hw/rtl/hse_pkg.sv
// ----------------------------------------------------------------------------
// hse_pkg
// Shared constants, queue entry type and sequencer states for the heap sorter.
// ----------------------------------------------------------------------------
package hse_pkg;

	localparam int MAX_ITEMS  = 64;
	localparam int DATA_W     = 32;
	localparam int ADDR_W     = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
	localparam int CNT_W      = ADDR_W + 1;
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_W = FIFO_PTR_W + 1;

	// one classified input transaction
	typedef struct packed {
		logic signed [DATA_W-1:0] value;
		logic                     last;
		logic                     drop;
	} entry_t;

	typedef enum logic [3:0] {
		S_LOAD,
		S_RDX,
		S_RDC,
		S_CMP,
		S_XCHK,
		S_XRD,
		S_XSW,
		S_ORD,
		S_OWR
	} state_t;

endpackage

### hw/rtl/heap_sort_engine_core.sv
// Operation: a batch of n values loads at one value per cycle, then sorts in place,
// one heap level per cycle, on a buffer with two read ports and one write port;
// results then leave one at a time in ascending order, each held until taken.
// A new batch that arrives during the sort waits in the queue, then at the input.
// Reset: asynchronous, active low; clears the sequencer, counts and queue.
// ----------------------------------------------------------------------------
// heap_sort_engine_core
// Batch heap sorter: front end classifies input, queue, sort/output back end.
// ----------------------------------------------------------------------------
module heap_sort_engine_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic signed [hse_pkg::DATA_W-1:0] value,
	input  logic                              last,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [hse_pkg::DATA_W-1:0] sorted_value,
	output logic                              last_out,
	output logic                              overflow
);

	logic            push_valid;
	logic            push_ready;
	hse_pkg::entry_t push_data;
	logic            pop_valid;
	logic            pop_ready;
	hse_pkg::entry_t pop_data;

	hse_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.value      (value),
		.last       (last),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	hse_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	hse_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.pop_valid    (pop_valid),
		.pop_ready    (pop_ready),
		.pop_data     (pop_data),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.sorted_value (sorted_value),
		.last_out     (last_out),
		.overflow     (overflow)
	);

endmodule

### hw/rtl/hse_front.sv
// ----------------------------------------------------------------------------
// hse_front
// Accepts input transactions, tracks the batch fill and marks values that
// no longer fit in the buffer.
// ----------------------------------------------------------------------------
module hse_front (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic signed [hse_pkg::DATA_W-1:0]   value,
	input  logic                                last,
	output logic                                push_valid,
	input  logic                                push_ready,
	output hse_pkg::entry_t                     push_data
);

	logic [hse_pkg::CNT_W-1:0] fill_q;
	logic                      full;
	logic                      accept;

	assign full     = (fill_q == hse_pkg::CNT_W'(hse_pkg::MAX_ITEMS));
	assign in_ready = push_ready;
	assign accept   = in_valid && push_ready;

	assign push_valid      = in_valid;
	assign push_data.value = value;
	assign push_data.last  = last;
	assign push_data.drop  = full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (accept) begin
			if (last) begin
				fill_q <= '0;
			end else if (!full) begin
				fill_q <= fill_q + 1'b1;
			end
		end
	end

endmodule

### hw/rtl/hse_fifo.sv
// ----------------------------------------------------------------------------
// hse_fifo
// Short queue that decouples the input side from the sort sequencer.
// ----------------------------------------------------------------------------
module hse_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push_valid,
	output logic            push_ready,
	input  hse_pkg::entry_t push_data,
	output logic            pop_valid,
	input  logic            pop_ready,
	output hse_pkg::entry_t pop_data
);

	hse_pkg::entry_t                   slot_q [hse_pkg::FIFO_DEPTH];
	logic [hse_pkg::FIFO_PTR_W-1:0]    wptr_q;
	logic [hse_pkg::FIFO_PTR_W-1:0]    rptr_q;
	logic [hse_pkg::FIFO_CNT_W-1:0]    cnt_q;
	logic                              push;
	logic                              pop;

	assign push_ready = (cnt_q != hse_pkg::FIFO_CNT_W'(hse_pkg::FIFO_DEPTH));
	assign pop_valid  = (cnt_q != '0);
	assign pop_data   = slot_q[rptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= rptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wptr_q] <= push_data;
		end
	end

endmodule

### hw/rtl/hse_back.sv
// ----------------------------------------------------------------------------
// hse_back
// Buffers a batch, heap sorts it in place with one tree level per cycle and
// streams it out in ascending order.
// ----------------------------------------------------------------------------
module hse_back (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              pop_valid,
	output logic                              pop_ready,
	input  hse_pkg::entry_t                   pop_data,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [hse_pkg::DATA_W-1:0] sorted_value,
	output logic                              last_out,
	output logic                              overflow
);

	localparam int AW = hse_pkg::ADDR_W;
	localparam int CW = hse_pkg::CNT_W;

	hse_pkg::state_t state_q;
	hse_pkg::state_t state_d;

	logic signed [hse_pkg::DATA_W-1:0] mem [hse_pkg::MAX_ITEMS];
	logic signed [hse_pkg::DATA_W-1:0] rd_a_q;
	logic signed [hse_pkg::DATA_W-1:0] rd_b_q;
	logic signed [hse_pkg::DATA_W-1:0] x_q;
	logic signed [hse_pkg::DATA_W-1:0] out_val_q;
	logic                              out_last_q;
	logic                              out_ovf_q;
	logic                              out_valid_q;

	logic [CW-1:0] count_q;
	logic [CW-1:0] sz_q;
	logic          ovf_q;
	logic          build_q;
	logic [AW-1:0] node_q;
	logic [AW-1:0] bi_q;
	logic [AW-1:0] oi_q;

	// memory port controls
	logic                              we;
	logic [AW-1:0]                     waddr;
	logic signed [hse_pkg::DATA_W-1:0] wdata;
	logic [AW-1:0]                     ra;
	logic [AW-1:0]                     rb;
	logic [AW-1:0]                     nn;
	logic                              use_children;
	logic [AW:0]                       ch_l;
	logic [AW:0]                       ch_r;

	// sift-down compare
	logic [AW+1:0]                     l_w;
	logic [AW+1:0]                     r_w;
	logic                              l_ok;
	logic                              r_ok;
	logic                              r_wins;
	logic [AW-1:0]                     c_idx;
	logic signed [hse_pkg::DATA_W-1:0] c_val;
	logic                              go_down;

	logic          pop;
	logic [CW-1:0] n_new;
	logic [CW-1:0] half;
	logic [CW-1:0] half_m1;
	logic [CW-1:0] sz_m1;
	logic          out_free;
	logic          out_is_last;

	assign pop     = pop_valid && pop_ready;
	assign n_new   = count_q + CW'(!pop_data.drop);
	assign half    = n_new >> 1;
	assign half_m1 = half - 1'b1;
	assign sz_m1   = sz_q - 1'b1;

	assign l_w     = {1'b0, node_q, 1'b1};
	assign r_w     = l_w + 1'b1;
	assign l_ok    = (l_w < {1'b0, sz_q});
	assign r_ok    = (r_w < {1'b0, sz_q});
	assign r_wins  = r_ok && (rd_b_q > rd_a_q);
	assign c_idx   = r_wins ? r_w[AW-1:0] : l_w[AW-1:0];
	assign c_val   = r_wins ? rd_b_q : rd_a_q;
	assign go_down = l_ok && (c_val > x_q);

	assign ch_l = {nn, 1'b1};
	assign ch_r = ch_l + 1'b1;

	assign out_free    = !out_valid_q || out_ready;
	assign out_is_last = (({1'b0, oi_q} + 1'b1) == count_q);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			hse_pkg::S_LOAD: begin
				if (pop_valid && pop_data.last) begin
					state_d = (half != '0) ? hse_pkg::S_RDX : hse_pkg::S_XCHK;
				end
			end
			hse_pkg::S_RDX: state_d = hse_pkg::S_RDC;
			hse_pkg::S_RDC: state_d = hse_pkg::S_CMP;
			hse_pkg::S_CMP: begin
				if (!go_down) begin
					if (build_q && (bi_q != '0)) begin
						state_d = hse_pkg::S_RDX;
					end else begin
						state_d = hse_pkg::S_XCHK;
					end
				end
			end
			hse_pkg::S_XCHK: begin
				state_d = (sz_q > CW'(1)) ? hse_pkg::S_XRD : hse_pkg::S_ORD;
			end
			hse_pkg::S_XRD: state_d = hse_pkg::S_XSW;
			hse_pkg::S_XSW: state_d = hse_pkg::S_CMP;
			hse_pkg::S_ORD: begin
				if (out_free) begin
					state_d = hse_pkg::S_OWR;
				end
			end
			hse_pkg::S_OWR: begin
				state_d = out_is_last ? hse_pkg::S_LOAD : hse_pkg::S_ORD;
			end
			default: state_d = hse_pkg::S_LOAD;
		endcase
	end

	// memory and queue controls
	always_comb begin
		pop_ready    = 1'b0;
		we           = 1'b0;
		waddr        = node_q;
		wdata        = x_q;
		ra           = '0;
		rb           = '0;
		nn           = node_q;
		use_children = 1'b0;
		case (state_q)
			hse_pkg::S_LOAD: begin
				pop_ready = 1'b1;
				we        = pop_valid && !pop_data.drop;
				waddr     = count_q[AW-1:0];
				wdata     = pop_data.value;
			end
			hse_pkg::S_RDX: begin
				ra = node_q;
			end
			hse_pkg::S_RDC: begin
				use_children = 1'b1;
			end
			hse_pkg::S_CMP: begin
				we           = 1'b1;
				wdata        = go_down ? c_val : x_q;
				nn           = c_idx;
				use_children = 1'b1;
			end
			hse_pkg::S_XRD: begin
				ra = '0;
				rb = sz_m1[AW-1:0];
			end
			hse_pkg::S_XSW: begin
				// root goes to the freed tail slot; old tail sifts from the root
				we           = 1'b1;
				waddr        = sz_m1[AW-1:0];
				wdata        = rd_a_q;
				nn           = '0;
				use_children = 1'b1;
			end
			hse_pkg::S_ORD: begin
				ra = oi_q;
			end
			default: begin
			end
		endcase
		if (use_children) begin
			ra = ch_l[AW-1:0];
			rb = ch_r[AW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rd_a_q <= mem[ra];
		rd_b_q <= mem[rb];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= hse_pkg::S_LOAD;
			count_q     <= '0;
			sz_q        <= '0;
			ovf_q       <= 1'b0;
			build_q     <= 1'b0;
			node_q      <= '0;
			bi_q        <= '0;
			oi_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				hse_pkg::S_LOAD: begin
					if (pop) begin
						count_q <= n_new;
						if (pop_data.drop) begin
							ovf_q <= 1'b1;
						end
						if (pop_data.last) begin
							sz_q    <= n_new;
							build_q <= 1'b1;
							bi_q    <= half_m1[AW-1:0];
							node_q  <= half_m1[AW-1:0];
						end
					end
				end
				hse_pkg::S_CMP: begin
					if (go_down) begin
						node_q <= c_idx;
					end else if (build_q && (bi_q != '0)) begin
						bi_q   <= bi_q - 1'b1;
						node_q <= bi_q - 1'b1;
					end
				end
				hse_pkg::S_XCHK: begin
					build_q <= 1'b0;
					oi_q    <= '0;
				end
				hse_pkg::S_XSW: begin
					sz_q   <= sz_m1;
					node_q <= '0;
				end
				hse_pkg::S_OWR: begin
					oi_q <= oi_q + 1'b1;
					if (out_is_last) begin
						count_q <= '0;
						ovf_q   <= 1'b0;
					end
				end
				default: begin
				end
			endcase
			if (state_q == hse_pkg::S_OWR) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == hse_pkg::S_RDC) begin
			x_q <= rd_a_q;
		end else if (state_q == hse_pkg::S_XSW) begin
			x_q <= rd_b_q;
		end
		if (state_q == hse_pkg::S_OWR) begin
			out_val_q  <= rd_a_q;
			out_last_q <= out_is_last;
			out_ovf_q  <= ovf_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign sorted_value = out_val_q;
	assign last_out     = out_last_q;
	assign overflow     = out_ovf_q;

endmodule
